>>> rtl/pwmrf_pkg.sv
`timescale 1ns / 1ps
package pwmrf_pkg;

  localparam int RegCount     = 256;
  localparam int ReadBurstDef = 70;
  localparam int ChannelsDef  = 16;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [7:0] ADDR_MODE1     = 8'h00;
  localparam logic [7:0] ADDR_PRESCALE  = 8'hFE;
  localparam logic [7:0] ADDR_ALL_OFF_H = 8'hFD;
  localparam logic [7:0] FIRST_OFF_H    = 8'd9;
  localparam logic [7:0] CTRL_LIMIT     = 8'd6;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  channel;
    logic        all_channels;
    logic [11:0] on_count;
    logic [11:0] off_count;
    logic [7:0]  clock_divider;
    logic [7:0]  read_first;
    logic [7:0]  read_second;
    logic [1:0]  bytes_valid;
    logic        last;
  } rsp_t;

  // power-on contents of the register file
  function automatic logic [7:0] reg_default(input logic [7:0] addr);
    logic [7:0] v;
    case (addr)
      8'h00:         v = 8'h88;
      8'h01:         v = 8'h20;
      8'h02:         v = 8'hE2;
      8'h03:         v = 8'hE4;
      8'h04:         v = 8'hE8;
      8'h05:         v = 8'hE0;
      ADDR_PRESCALE: v = 8'hC8;
      default:       v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/pwmrf_regmem.sv
`timescale 1ns / 1ps
module pwmrf_regmem (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [7:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic       rd_en,
  input  logic [7:0] rd_addr,
  output logic [7:0] rd_data
);
  import pwmrf_pkg::*;

  logic [7:0]          mem [RegCount];
  logic [RegCount-1:0] written;
  logic [7:0]          mem_q;
  logic [7:0]          dflt_q;
  logic                hit_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit_q  <= written[rd_addr];
      dflt_q <= reg_default(rd_addr);
    end
  end

  assign rd_data = hit_q ? mem_q : dflt_q;

endmodule

>>> rtl/pwm_led_controller_register_front.sv
`timescale 1ns / 1ps
// Register front of a 16-channel PWM LED controller. Each cmd transfer is one
// bus event: a written byte, a read request or a stop. The 256-byte register
// file sits in one synchronous memory with a single read port; power-on
// defaults come from per-entry written bits cleared at reset, so there is no
// clearing pass. A write that only loads the pointer or stores a plain
// register is done when it is accepted. A write to a channel's or the all-LED
// OFF_H byte reads four bytes through the read port before its update is put
// in the output register. A read returns results of one or two bytes each, a
// single byte or, with auto-increment, the 70-byte burst; each result waits
// for the previous one to leave the output register. cmd_ready is high only
// between items; a result waiting in the output register does not hold off
// the next item.
module pwm_led_controller_register_front #(
  parameter int READ_BURST = pwmrf_pkg::ReadBurstDef,
  parameter int CHANNELS   = pwmrf_pkg::ChannelsDef
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  pwmrf_pkg::cmd_t cmd,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output pwmrf_pkg::rsp_t rsp
);
  import pwmrf_pkg::*;

  localparam int CW = $clog2(READ_BURST + 3);
  localparam logic [7:0] CHAN_END = 8'(9 + 4 * CHANNELS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]    state;
  logic [7:0]    pointer;
  logic          loaded;
  logic          ai;
  logic          upd;
  logic          all;
  logic [7:0]    base;
  logic [3:0]    off_h;
  logic [2:0]    j;
  logic [CW-1:0] idx;
  logic [CW-1:0] total;
  logic [7:0]    b [4];

  logic          accept;
  logic          is_chan;
  logic          is_all;
  logic [CW-1:0] rem;
  logic          two_left;
  logic          last_r;
  logic [2:0]    nb;
  logic [1:0]    jm1;
  logic [7:0]    chan_off;
  logic          wr_en;
  logic          rd_en;
  logic [7:0]    rd_addr;
  logic [7:0]    rd_data;
  logic          rsp_load;
  rsp_t          rsp_next;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;

  assign is_chan = (pointer >= FIRST_OFF_H) && (pointer < CHAN_END) && (pointer[1:0] == 2'b01);
  assign is_all  = (pointer == ADDR_ALL_OFF_H);

  assign rem      = total - idx;
  assign two_left = (rem >= CW'(2));
  assign last_r   = (rem <= CW'(2));
  assign nb       = upd ? 3'd4 : (two_left ? 3'd2 : 3'd1);
  assign jm1      = 2'(j - 3'd1);
  assign chan_off = base - FIRST_OFF_H;
  assign rsp_load = (state == S_EMIT) && (!rsp_valid || rsp_ready);

  assign wr_en = accept && (cmd.operation == OP_WRITE) && loaded;
  assign rd_en = (state == S_RUN) && (j < nb);

  always_comb begin
    if (upd) begin
      rd_addr = (j == 3'd3) ? ADDR_PRESCALE : 8'(base - 8'd3 + 8'(j));
    end else begin
      rd_addr = 8'(pointer + 8'(idx) + 8'(j));
    end
  end

  pwmrf_regmem u_regmem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (pointer),
    .wr_data (cmd.data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    rsp_next = '0;
    if (upd) begin
      rsp_next.kind          = KIND_UPDATE;
      rsp_next.channel       = all ? 4'd0 : chan_off[5:2];
      rsp_next.all_channels  = all;
      rsp_next.on_count      = {b[1][3:0], b[0]};
      rsp_next.off_count     = {off_h, b[2]};
      rsp_next.clock_divider = b[3];
      rsp_next.last          = 1'b1;
    end else begin
      rsp_next.kind        = KIND_READ;
      rsp_next.read_first  = b[0];
      rsp_next.read_second = two_left ? b[1] : 8'd0;
      rsp_next.bytes_valid = two_left ? 2'd2 : 2'd1;
      rsp_next.last        = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pointer   <= '0;
      loaded    <= 1'b0;
      ai        <= 1'b0;
      upd       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.operation == OP_WRITE) begin
              if (!loaded) begin
                loaded  <= 1'b1;
                pointer <= cmd.data_byte;
              end else begin
                pointer <= pointer + 8'd1;
                if (pointer == ADDR_MODE1) begin
                  ai <= cmd.data_byte[5];
                end
                if (is_chan || is_all) begin
                  if (!ai) begin
                    loaded <= 1'b0;
                  end
                  upd   <= 1'b1;
                  all   <= is_all;
                  base  <= pointer;
                  off_h <= cmd.data_byte[3:0];
                  j     <= '0;
                  state <= S_RUN;
                end
                if (pointer < CTRL_LIMIT) begin
                  loaded <= 1'b0;
                end
              end
            end else if (cmd.operation == OP_READ) begin
              loaded <= 1'b0;
              ai     <= 1'b0;
              total  <= ai ? CW'(READ_BURST) : CW'(1);
              idx    <= '0;
              upd    <= 1'b0;
              j      <= '0;
              state  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (j != 3'd0) begin
            b[jm1] <= rd_data;
          end
          j <= j + 3'd1;
          if (j == nb) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (rsp_load) begin
            rsp_valid <= 1'b1;
            rsp       <= rsp_next;
            j         <= '0;
            if (upd || last_r) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + CW'(nb);
              state <= S_RUN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // memory port interlock: writes only between items, reads only inside one
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("register file written and read in one cycle");

  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.operation == OP_READ) |=> (state == S_RUN) && !ai && !loaded)
    else $error("read request did not clear pointer and auto-increment");

  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) && !upd |-> (idx < total))
    else $error("read burst index past its length");

  a_update_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind == KIND_UPDATE) |-> rsp.last && (rsp.bytes_valid == 2'd0))
    else $error("channel update not a single final result");

  a_read_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind == KIND_READ) |-> (rsp.bytes_valid != 2'd0))
    else $error("read result without data bytes");

endmodule

>>> test/tb_pwm_led_controller_register_front.sv
`timescale 1ns / 1ps
module tb_pwm_led_controller_register_front;
  import pwmrf_pkg::*;

  localparam logic [1:0] OP_STOP = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [7:0] MODE_AI        = 8'h20;
  localparam logic [7:0] ADDR_ALL_ON_L  = ADDR_ALL_OFF_H - 8'd3;
  localparam logic [7:0] LAST_OFF_H     = FIRST_OFF_H + 8'd4 * 8'(ChannelsDef - 1);
  localparam logic [7:0] PAST_OFF_H     = LAST_OFF_H + 8'd4;
  localparam logic [7:0] ADDR_WRAP_FROM = 8'hE0;

  localparam int RANDOM_EVENTS = 280;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    cmd_t c;
    logic typed;
    rsp_t want;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic [7:0] pred_regs [0:RegCount-1];
  logic [7:0] pred_ptr;
  logic       pred_loaded;
  logic       pred_auto;

  rsp_t      awaited_results[$];
  stim_row_t directed_rows[$];

  int mismatches = 0;
  int events_sent = 0;
  int updates_seen = 0;
  int reads_seen = 0;
  int burst_left = 1;
  int cycles = 0;
  logic directed_done = 1'b0;
  logic long_hold_done = 1'b0;

  pwm_led_controller_register_front dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pwm_led_controller_register_front regression: fail");
      $finish;
    end
  end

  task automatic pred_reset();
    for (int i = 0; i < RegCount; i++) pred_regs[i] = 8'h00;
    pred_regs[ADDR_MODE1]         = 8'h88;
    pred_regs[ADDR_MODE1 + 8'd1]  = 8'h20;
    pred_regs[ADDR_MODE1 + 8'd2]  = 8'hE2;
    pred_regs[ADDR_MODE1 + 8'd3]  = 8'hE4;
    pred_regs[ADDR_MODE1 + 8'd4]  = 8'hE8;
    pred_regs[ADDR_MODE1 + 8'd5]  = 8'hE0;
    pred_regs[ADDR_PRESCALE]      = 8'hC8;
    pred_ptr    = 8'h00;
    pred_loaded = 1'b0;
    pred_auto   = 1'b0;
  endtask

  // applies one bus event to the register shadow, returns the results it causes
  task automatic bus_event_effect(input cmd_t c, ref rsp_t outs[$]);
    logic [7:0] a;
    logic [7:0] p;
    int         ai;
    int         count;
    logic       chan_hit;
    rsp_t       r;
    outs.delete();
    if (c.operation == OP_WRITE) begin
      if (!pred_loaded) begin
        pred_loaded = 1'b1;
        pred_ptr = c.data_byte;
      end else begin
        a = pred_ptr;
        ai = int'(a);
        pred_regs[a] = c.data_byte;
        if (a == ADDR_MODE1) pred_auto = c.data_byte[5];
        chan_hit = ai >= int'(FIRST_OFF_H) && ai < int'(FIRST_OFF_H) + 4 * ChannelsDef &&
                   ((ai - int'(FIRST_OFF_H)) % 4) == 0;
        if (chan_hit || a == ADDR_ALL_OFF_H) begin
          if (!pred_auto) pred_loaded = 1'b0;
          r = '0;
          r.kind = KIND_UPDATE;
          r.channel = chan_hit ? 4'((ai - int'(FIRST_OFF_H)) / 4) : 4'd0;
          r.all_channels = !chan_hit;
          r.on_count = {pred_regs[a - 8'd2][3:0], pred_regs[a - 8'd3]};
          r.off_count = {pred_regs[a][3:0], pred_regs[a - 8'd1]};
          r.clock_divider = pred_regs[ADDR_PRESCALE];
          r.last = 1'b1;
          outs.push_back(r);
        end
        if (a < CTRL_LIMIT) pred_loaded = 1'b0;
        pred_ptr = a + 8'd1;
      end
    end else if (c.operation == OP_READ) begin
      count = pred_auto ? ReadBurstDef : 1;
      pred_loaded = 1'b0;
      pred_auto = 1'b0;
      for (int i = 0; i < count; i += 2) begin
        r = '0;
        r.kind = KIND_READ;
        p = pred_ptr + 8'(i);
        r.read_first = pred_regs[p];
        if (i + 1 < count) begin
          r.read_second = pred_regs[p + 8'd1];
          r.bytes_valid = 2'd2;
        end else begin
          r.bytes_valid = 2'd1;
        end
        r.last = (i + 2 >= count);
        outs.push_back(r);
      end
    end
  endtask

  function automatic stim_row_t ev(logic [1:0] op, logic [7:0] b);
    stim_row_t s;
    s = '0;
    s.c.operation = op;
    s.c.data_byte = b;
    return s;
  endfunction

  function automatic stim_row_t ev_want(logic [1:0] op, logic [7:0] b, rsp_t want);
    stim_row_t s;
    s = ev(op, b);
    s.typed = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic rsp_t read_rsp(logic [7:0] b);
    rsp_t r;
    r = '0;
    r.kind = KIND_READ;
    r.read_first = b;
    r.bytes_valid = 2'd1;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic rsp_t update_rsp(logic [3:0] ch, logic all, logic [11:0] on,
                                      logic [11:0] off, logic [7:0] div);
    rsp_t r;
    r = '0;
    r.kind = KIND_UPDATE;
    r.channel = ch;
    r.all_channels = all;
    r.on_count = on;
    r.off_count = off;
    r.clock_divider = div;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic offer_event(input stim_row_t s);
    rsp_t outs[$];
    @(negedge clk);
    cmd_valid = 1'b1;
    cmd = s.c;
    do @(posedge clk); while (!cmd_ready);
    bus_event_effect(s.c, outs);
    if (s.typed) awaited_results.push_back(s.want);
    else foreach (outs[i]) awaited_results.push_back(outs[i]);
    if (s.c.operation == OP_WRITE || s.c.operation == OP_READ) events_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      cmd_valid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
  endtask

  task automatic put(logic [1:0] op, logic [7:0] b);
    offer_event(ev(op, b));
  endtask

  task automatic random_sequence();
    int         pick;
    int         n;
    logic [7:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if (!pred_loaded) begin
        ch = 8'($urandom_range(0, ChannelsDef - 1));
        if ($urandom_range(0, 7) == 0) put(OP_WRITE, ADDR_ALL_ON_L);
        else put(OP_WRITE, FIRST_OFF_H - 8'd3 + 8'd4 * ch);
      end
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : 4;
      repeat (n) put(OP_WRITE, 8'($urandom_range(0, 255)));
    end else if (pick < 55) begin
      if (pred_loaded) put(OP_READ, 8'($urandom_range(0, 255)));
      put(OP_WRITE, ADDR_MODE1);
      put(OP_WRITE, 8'($urandom_range(0, 255)));
    end else if (pick < 62) begin
      if (!pred_loaded) put(OP_WRITE, ADDR_PRESCALE);
      put(OP_WRITE, 8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      if (!pred_loaded && $urandom_range(0, 1) == 1) put(OP_WRITE, 8'($urandom_range(0, 255)));
      put(OP_READ, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) put(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: randomly chosen stall patterns, with one long hold-off once the random traffic starts
  initial begin
    rx_mode_e mode;
    int       left;
    mode = RX_OPEN;
    left = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (directed_done && !long_hold_done) begin
        rsp_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        RX_OPEN:     rsp_ready = 1'b1;
        RX_RANDOM:   rsp_ready = ($urandom_range(0, 99) < 70);
        RX_PERIODIC: rsp_ready = (left % 3 == 0);
        default:     rsp_ready = ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", rsp);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 12'(want.kind), 12'(rsp.kind));
        check_field("channel", 12'(want.channel), 12'(rsp.channel));
        check_field("all_channels", 12'(want.all_channels), 12'(rsp.all_channels));
        check_field("on_count", want.on_count, rsp.on_count);
        check_field("off_count", want.off_count, rsp.off_count);
        check_field("clock_divider", 12'(want.clock_divider), 12'(rsp.clock_divider));
        check_field("read_first", 12'(want.read_first), 12'(rsp.read_first));
        check_field("read_second", 12'(want.read_second), 12'(rsp.read_second));
        check_field("bytes_valid", 12'(want.bytes_valid), 12'(rsp.bytes_valid));
        check_field("last", 12'(want.last), 12'(rsp.last));
      end
      if (rsp.kind == KIND_UPDATE) updates_seen++;
      else reads_seen++;
    end
  end

  initial begin
    int target;
    directed_rows.push_back(ev_want(OP_READ, 8'h00, read_rsp(8'h88)));
    directed_rows.push_back(ev(OP_STOP, 8'h00));
    directed_rows.push_back(ev(OP_RSVD, 8'hFF));
    directed_rows.push_back(ev(OP_WRITE, FIRST_OFF_H));
    directed_rows.push_back(ev_want(OP_WRITE, 8'hFF,
                                    update_rsp(4'd0, 1'b0, 12'h000, 12'hF00, 8'hC8)));
    directed_rows.push_back(ev(OP_WRITE, ADDR_MODE1));
    directed_rows.push_back(ev(OP_WRITE, MODE_AI | 8'h80));
    directed_rows.push_back(ev(OP_WRITE, ADDR_ALL_ON_L));
    directed_rows.push_back(ev(OP_WRITE, 8'hFF));
    directed_rows.push_back(ev(OP_WRITE, 8'hFF));
    directed_rows.push_back(ev(OP_WRITE, 8'hFF));
    directed_rows.push_back(ev_want(OP_WRITE, 8'hFF,
                                    update_rsp(4'd0, 1'b1, 12'hFFF, 12'hFFF, 8'hC8)));
    directed_rows.push_back(ev(OP_WRITE, 8'h03));
    directed_rows.push_back(ev(OP_WRITE, 8'h00));
    directed_rows.push_back(ev(OP_WRITE, MODE_AI));
    directed_rows.push_back(ev(OP_READ, 8'h00));
    directed_rows.push_back(ev_want(OP_READ, 8'hFF, read_rsp(8'h20)));
    directed_rows.push_back(ev(OP_WRITE, LAST_OFF_H));
    directed_rows.push_back(ev(OP_WRITE, 8'h00));
    directed_rows.push_back(ev(OP_WRITE, PAST_OFF_H));
    directed_rows.push_back(ev(OP_WRITE, 8'h55));
    directed_rows.push_back(ev(OP_READ, 8'h00));
    directed_rows.push_back(ev(OP_WRITE, ADDR_MODE1));
    directed_rows.push_back(ev(OP_WRITE, MODE_AI));
    directed_rows.push_back(ev(OP_WRITE, ADDR_WRAP_FROM));
    directed_rows.push_back(ev(OP_READ, 8'h00));

    pred_reset();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) offer_event(directed_rows[i]);
    directed_done = 1'b1;

    target = events_sent + RANDOM_EVENTS;
    while (events_sent < target) random_sequence();
    @(negedge clk);
    cmd_valid = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d writes and reads sent; %0d channel updates and %0d read transfers checked",
             events_sent, updates_seen, reads_seen);
    if (mismatches == 0) begin
      $display("pwm_led_controller_register_front regression: pass");
    end else begin
      $display("pwm_led_controller_register_front regression: fail");
    end
    $finish;
  end

endmodule
